/* rtl/tcw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: command codes,
// character codes, configuration register indexes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// command codes of an input item
	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_SET   = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_ATTR  = 2'd0,
		CFG_SHIFT = 2'd1
	} cfg_idx_t;

	// character codes with a meaning of their own
	localparam logic [7:0] CH_BS        = 8'h08;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] SHIFT_OFFSET = 8'd32;
	localparam logic [7:0] RESET_ATTR   = 8'h1F;

	// class of a put character
	typedef enum logic [2:0] {
		CL_BS,
		CL_TAB,
		CL_CR,
		CL_LF,
		CL_PRINT,
		CL_OTHER
	} cls_t;

	// where the cell address points
	typedef enum logic [1:0] {
		TS_CURSOR,
		TS_INPUT,
		TS_LINE
	} tsel_t;

	// what a single cell write stores
	typedef enum logic {
		WS_BLANK,
		WS_CHAR
	} wsel_t;

	// controller to datapath
	typedef struct packed {
		logic  latch;
		logic  set_cursor;
		logic  clear_start;
		logic  col_back;
		logic  col_zero;
		logic  col_inc;
		logic  tab_quot;
		logic  col_tab;
		logic  new_line;
		logic  calc_row;
		tsel_t tsel;
		logic  calc_addr;
		logic  line_start;
		logic  mem_write;
		wsel_t wsel;
		logic  mem_read;
		logic  capture;
		logic  sweep_step;
		logic  calc_index;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		cls_t cls;
		logic in_range;
		logic col_over;
		logic row_last;
		logic sweep_last;
	} dp_stat_t;

endpackage
`default_nettype wire

/* rtl/tcw_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-port RAM with one write or registered read per cycle.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/tcw_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller of the text console writer: walks one item through decode,
// tabs, address calculation, cell access, line wrap, scroll, clear and result.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output logic                    done,
	output tcw_pkg::dp_cmd_t        dcmd,
	input  wire tcw_pkg::dp_stat_t  stat
);

	import tcw_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE    = 13'b0000000000001,
		ST_DECODE  = 13'b0000000000010,
		ST_TABQ    = 13'b0000000000100,
		ST_TABSET  = 13'b0000000001000,
		ST_ROWCALC = 13'b0000000010000,
		ST_ADDR    = 13'b0000000100000,
		ST_ACCESS  = 13'b0000001000000,
		ST_RDWAIT  = 13'b0000010000000,
		ST_CHECK   = 13'b0000100000000,
		ST_NEWLINE = 13'b0001000000000,
		ST_SWEEP   = 13'b0010000000000,
		ST_INDEX   = 13'b0100000000000,
		ST_DONE    = 13'b1000000000000
	} state_t;

	typedef enum logic [1:0] {
		MD_BLANK,
		MD_CHAR,
		MD_READ,
		MD_LINE
	} mode_t;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;
	logic   init_done_q, init_done_d;

	// next state and datapath commands
	always_comb begin
		state_d     = state_q;
		mode_d      = mode_q;
		init_done_d = init_done_q;
		dcmd        = '0;
		dcmd.tsel   = TS_CURSOR;
		dcmd.wsel   = WS_BLANK;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					dcmd.latch = 1'b1;
					state_d    = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (stat.cmd)
					CMD_PUT: begin
						unique case (stat.cls)
							CL_BS: begin
								dcmd.col_back = 1'b1;
								mode_d        = MD_BLANK;
								state_d       = ST_ROWCALC;
							end
							CL_TAB: begin
								state_d = ST_TABQ;
							end
							CL_CR: begin
								dcmd.col_zero = 1'b1;
								state_d       = ST_INDEX;
							end
							CL_LF: begin
								state_d = ST_NEWLINE;
							end
							CL_PRINT: begin
								mode_d  = MD_CHAR;
								state_d = ST_ROWCALC;
							end
							CL_OTHER: begin
								state_d = ST_INDEX;
							end
							default: begin
								state_d = ST_INDEX;
							end
						endcase
					end
					CMD_CLEAR: begin
						dcmd.clear_start = 1'b1;
						state_d          = ST_SWEEP;
					end
					CMD_SET: begin
						dcmd.set_cursor = 1'b1;
						state_d         = ST_INDEX;
					end
					CMD_READ: begin
						if (stat.in_range) begin
							mode_d  = MD_READ;
							state_d = ST_ROWCALC;
						end else begin
							state_d = ST_INDEX;
						end
					end
					default: begin
						state_d = ST_INDEX;
					end
				endcase
			end
			ST_TABQ: begin
				dcmd.tab_quot = 1'b1;
				state_d       = ST_TABSET;
			end
			ST_TABSET: begin
				dcmd.col_tab = 1'b1;
				state_d      = ST_CHECK;
			end
			ST_ROWCALC: begin
				dcmd.calc_row = 1'b1;
				if (mode_q == MD_READ) begin
					dcmd.tsel = TS_INPUT;
				end else if (mode_q == MD_LINE) begin
					dcmd.tsel = TS_LINE;
				end
				state_d = ST_ADDR;
			end
			ST_ADDR: begin
				dcmd.calc_addr = 1'b1;
				if (mode_q == MD_LINE) begin
					dcmd.line_start = 1'b1;
					state_d         = ST_SWEEP;
				end else begin
					state_d = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				unique case (mode_q)
					MD_BLANK: begin
						dcmd.mem_write = 1'b1;
						state_d        = ST_INDEX;
					end
					MD_CHAR: begin
						dcmd.mem_write = 1'b1;
						dcmd.wsel      = WS_CHAR;
						dcmd.col_inc   = 1'b1;
						state_d        = ST_CHECK;
					end
					MD_READ: begin
						dcmd.mem_read = 1'b1;
						state_d       = ST_RDWAIT;
					end
					default: begin
						state_d = ST_INDEX;
					end
				endcase
			end
			ST_RDWAIT: begin
				dcmd.capture = 1'b1;
				state_d      = ST_INDEX;
			end
			ST_CHECK: begin
				state_d = stat.col_over ? ST_NEWLINE : ST_INDEX;
			end
			ST_NEWLINE: begin
				dcmd.new_line = 1'b1;
				if (stat.row_last) begin
					mode_d  = MD_LINE;
					state_d = ST_ROWCALC;
				end else begin
					state_d = ST_INDEX;
				end
			end
			ST_SWEEP: begin
				dcmd.sweep_step = 1'b1;
				if (stat.sweep_last) begin
					init_done_d = 1'b1;
					state_d     = init_done_q ? ST_INDEX : ST_IDLE;
				end
			end
			ST_INDEX: begin
				dcmd.calc_index = 1'b1;
				state_d         = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers, reset starts the power-up clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			mode_q      <= MD_BLANK;
			init_done_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			mode_q      <= mode_d;
			init_done_q <= init_done_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state is not one-hot");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("item accepted but block not busy");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_idle_col: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !stat.col_over)
		else $error("cursor column past the screen while idle");

endmodule
`default_nettype wire

/* rtl/tcw_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath
// Datapath of the text console writer: configuration registers, item
// latch, cursor and top-row pointer, address arithmetic, sweep counter
// and the screen cell memory.
// ----------------------------------------------------------------------------
module tcw_datapath #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25,
	parameter int TAB_WIDTH      = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tcw_pkg::dp_cmd_t  dcmd,
	output tcw_pkg::dp_stat_t      stat,
	input  wire logic [1:0]        cmd,
	input  wire logic [7:0]        char_code,
	input  wire logic [4:0]        row,
	input  wire logic [6:0]        column,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [7:0]        cfg_data,
	output logic      [10:0]       cursor_index,
	output logic      [4:0]        cursor_row_out,
	output logic      [6:0]        cursor_col_out,
	output logic      [15:0]       cell_data
);

	import tcw_pkg::*;

	localparam int CELLS     = SCREEN_ROWS * SCREEN_COLUMNS;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int ROW_W     = $clog2(SCREEN_ROWS);
	localparam int ROWX_W    = ROW_W + 1;
	localparam int COL_W     = $clog2(SCREEN_COLUMNS);
	localparam int COLX_W    = $clog2(SCREEN_COLUMNS + TAB_WIDTH);
	localparam int TAB_SHIFT = 16;
	localparam int TAB_RECIP = 65536 / TAB_WIDTH;
	localparam int RP_W      = COLX_W + TAB_SHIFT;

	// configuration
	logic [7:0] attr_q;
	logic       shift_q;
	// latched item
	cmd_t       lat_cmd_q;
	logic [7:0] lat_char_q;
	logic [4:0] lat_row_q;
	logic [6:0] lat_col_q;
	// cursor and scroll pointer
	logic [ROW_W-1:0]  row_q;
	logic [COLX_W-1:0] col_q;
	logic [ROW_W-1:0]  top_q;
	// address and sweep
	logic [ROW_W-1:0]  phys_row_q;
	logic [COL_W-1:0]  tcol_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [15:0]       blank_q;
	// tab and results
	logic [COLX_W-1:0] quot_q;
	logic [15:0]       data_q;
	logic [ADDR_W-1:0] idx_q;

	cls_t              char_cls;
	logic [7:0]        lat_row_ext;
	logic [8:0]        lat_col_ext;
	logic [ROW_W-1:0]  trow;
	logic [COL_W-1:0]  tcol;
	logic [ROWX_W-1:0] row_sum;
	logic [ROW_W-1:0]  phys_row_d;
	logic [ADDR_W-1:0] addr_d;
	logic [ADDR_W-1:0] idx_d;
	logic [RP_W-1:0]   recip_prod;
	logic [COLX_W-1:0] tab_prod;
	logic [COLX_W-1:0] tab_rem;
	logic [COLX_W-1:0] tab_stop;
	logic [7:0]        char_adj;
	logic [15:0]       ram_wdata;
	logic [15:0]       ram_rdata;
	logic              ram_we;
	logic [15:0]       idx_ext;
	logic [7:0]        row_ext;
	logic [8:0]        col_ext;

	assign lat_row_ext = 8'(lat_row_q);
	assign lat_col_ext = 9'(lat_col_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q  <= RESET_ATTR;
			shift_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ATTR:  attr_q  <= cfg_data;
				CFG_SHIFT: shift_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// item latch
	always_ff @(posedge clk) begin
		if (dcmd.latch) begin
			lat_cmd_q  <= cmd_t'(cmd);
			lat_char_q <= char_code;
			lat_row_q  <= row;
			lat_col_q  <= column;
		end
	end

	// character class of the latched byte
	always_comb begin
		priority if (lat_char_q == CH_BS) begin
			char_cls = CL_BS;
		end else if (lat_char_q == CH_TAB) begin
			char_cls = CL_TAB;
		end else if (lat_char_q == CH_CR) begin
			char_cls = CL_CR;
		end else if (lat_char_q == CH_LF) begin
			char_cls = CL_LF;
		end else if (lat_char_q >= CH_SPACE) begin
			char_cls = CL_PRINT;
		end else begin
			char_cls = CL_OTHER;
		end
	end

	assign stat.cls        = char_cls;
	assign stat.cmd        = lat_cmd_q;
	assign stat.in_range   = (lat_row_ext < 8'(SCREEN_ROWS)) &&
	                         (lat_col_ext < 9'(SCREEN_COLUMNS));
	assign stat.col_over   = (col_q >= COLX_W'(SCREEN_COLUMNS));
	assign stat.row_last   = (row_q == ROW_W'(SCREEN_ROWS - 1));
	assign stat.sweep_last = (cnt_q == '0);

	// next tab stop: quotient by reciprocal, then one correction step
	assign recip_prod = RP_W'(col_q) * RP_W'(TAB_RECIP);
	assign tab_prod   = quot_q * COLX_W'(TAB_WIDTH);
	assign tab_rem    = col_q - tab_prod;
	assign tab_stop   = tab_prod + COLX_W'(TAB_WIDTH) +
	                    ((tab_rem >= COLX_W'(TAB_WIDTH)) ? COLX_W'(TAB_WIDTH) : '0);

	always_ff @(posedge clk) begin
		if (dcmd.tab_quot) begin
			quot_q <= recip_prod[RP_W-1:TAB_SHIFT];
		end
	end

	// cursor and top-row pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			top_q <= '0;
		end else begin
			priority if (dcmd.clear_start) begin
				row_q <= '0;
				col_q <= '0;
				top_q <= '0;
			end else if (dcmd.set_cursor) begin
				row_q <= (lat_row_ext < 8'(SCREEN_ROWS)) ? lat_row_ext[ROW_W-1:0]
				                                         : ROW_W'(SCREEN_ROWS - 1);
				col_q <= (lat_col_ext < 9'(SCREEN_COLUMNS)) ? lat_col_ext[COLX_W-1:0]
				                                            : COLX_W'(SCREEN_COLUMNS - 1);
			end else if (dcmd.col_back) begin
				if (col_q != '0) begin
					col_q <= col_q - COLX_W'(1);
				end
			end else if (dcmd.col_zero) begin
				col_q <= '0;
			end else if (dcmd.col_inc) begin
				col_q <= col_q + COLX_W'(1);
			end else if (dcmd.col_tab) begin
				col_q <= tab_stop;
			end else if (dcmd.new_line) begin
				col_q <= '0;
				if (!stat.row_last) begin
					row_q <= row_q + ROW_W'(1);
				end
			end else if (dcmd.line_start) begin
				top_q <= stat.row_last && (top_q == ROW_W'(SCREEN_ROWS - 1)) ? '0
				         : ((top_q == ROW_W'(SCREEN_ROWS - 1)) ? '0 : top_q + ROW_W'(1));
			end
		end
	end

	// target of the cell access
	always_comb begin
		unique case (dcmd.tsel)
			TS_INPUT: begin
				trow = lat_row_ext[ROW_W-1:0];
				tcol = lat_col_ext[COL_W-1:0];
			end
			TS_LINE: begin
				trow = '0;
				tcol = '0;
			end
			default: begin
				trow = row_q;
				tcol = col_q[COL_W-1:0];
			end
		endcase
	end

	// physical row through the rotating top pointer
	assign row_sum    = ROWX_W'(top_q) + ROWX_W'(trow);
	assign phys_row_d = (row_sum >= ROWX_W'(SCREEN_ROWS))
	                    ? ROW_W'(row_sum - ROWX_W'(SCREEN_ROWS))
	                    : row_sum[ROW_W-1:0];

	always_ff @(posedge clk) begin
		if (dcmd.calc_row) begin
			phys_row_q <= phys_row_d;
			tcol_q     <= tcol;
		end
	end

	// cell address and sweep counter
	assign addr_d = ADDR_W'(phys_row_q) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(tcol_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			cnt_q  <= ADDR_W'(CELLS - 1);
		end else begin
			priority if (dcmd.clear_start) begin
				addr_q <= '0;
				cnt_q  <= ADDR_W'(CELLS - 1);
			end else if (dcmd.calc_addr) begin
				addr_q <= addr_d;
				if (dcmd.line_start) begin
					cnt_q <= ADDR_W'(SCREEN_COLUMNS - 1);
				end
			end else if (dcmd.sweep_step) begin
				addr_q <= addr_q + ADDR_W'(1);
				cnt_q  <= cnt_q - ADDR_W'(1);
			end
		end
	end

	// blank cell in the attribute of the current item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_q <= {RESET_ATTR, CH_SPACE};
		end else if (dcmd.latch) begin
			blank_q <= {attr_q, CH_SPACE};
		end
	end

	// screen memory
	assign char_adj  = shift_q ? (lat_char_q - SHIFT_OFFSET) : lat_char_q;
	assign ram_we    = dcmd.mem_write || dcmd.sweep_step;
	assign ram_wdata = (dcmd.sweep_step || dcmd.wsel == WS_BLANK) ? blank_q
	                                                              : {attr_q, char_adj};

	tcw_ram #(
		.WIDTH (16),
		.DEPTH (CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (dcmd.mem_read),
		.addr  (addr_q),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// result registers
	assign idx_d = ADDR_W'(row_q) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col_q);

	always_ff @(posedge clk) begin
		if (dcmd.latch) begin
			data_q <= '0;
		end else if (dcmd.capture) begin
			data_q <= ram_rdata;
		end
		if (dcmd.calc_index) begin
			idx_q <= idx_d;
		end
	end

	assign idx_ext        = 16'(idx_q);
	assign row_ext        = 8'(row_q);
	assign col_ext        = 9'(col_q);
	assign cursor_index   = idx_ext[10:0];
	assign cursor_row_out = row_ext[4:0];
	assign cursor_col_out = col_ext[6:0];
	assign cell_data      = data_q;

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((ADDR_W + 1)'(addr_q) < (ADDR_W + 1)'(CELLS)))
		else $error("cell write outside the screen");

	a_rows_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q <= ROW_W'(SCREEN_ROWS - 1)) && (top_q <= ROW_W'(SCREEN_ROWS - 1)))
		else $error("cursor row or top pointer outside the screen");

endmodule
`default_nettype wire

/* rtl/text_console_writer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console writer: a screen of character cells with a cursor, fed
// by put-character, clear, set-cursor and read-cell commands.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result shows
// on the result ports for the single cycle in which done is high, and
// the receiver must take it then. The block works on one item at a time
// and is busy until the result is out; the next item can be taken at the
// end of the cycle after done. A set cursor, a CR, an ignored byte and an
// out-of-range read go from decode to the index step; a line feed passes
// the new-line step, a tab the tab quotient and tab-set steps, and a
// backspace, a printable byte or a read the row, address and cell access
// steps, a read then waiting for the registered memory data. A wrap adds
// the new-line step; a new line on the last row scrolls by moving the
// top-row pointer and blanking one line through the single memory port.
// Clear writes every cell, one per cycle.
// After reset the block is busy while it blanks the screen; configuration
// writes are taken at any time (cfg_ready is always high).
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25,
	parameter int TAB_WIDTH      = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  cmd,
	input  wire logic [7:0]  char_code,
	input  wire logic [4:0]  row,
	input  wire logic [6:0]  column,
	output logic             done,
	output logic      [10:0] cursor_index,
	output logic      [4:0]  cursor_row_out,
	output logic      [6:0]  cursor_col_out,
	output logic      [15:0] cell_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	import tcw_pkg::*;

	dp_cmd_t  dcmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	// sequencer
	tcw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.dcmd   (dcmd),
		.stat   (stat)
	);

	// registers, arithmetic and screen memory
	tcw_datapath #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS),
		.TAB_WIDTH      (TAB_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.dcmd           (dcmd),
		.stat           (stat),
		.cmd            (cmd),
		.char_code      (char_code),
		.row            (row),
		.column         (column),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cursor_index   (cursor_index),
		.cursor_row_out (cursor_row_out),
		.cursor_col_out (cursor_col_out),
		.cell_data      (cell_data)
	);

endmodule
`default_nettype wire
